// File: design/ols_pkg.sv
// shared types and codes for the ordered list search and remove block
`timescale 1ns / 1ps

package ols_pkg;

  // action codes
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_FIND   = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_COUNT  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] word_value;
    logic [3:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_word;
    logic [3:0]  found_position;
    logic [4:0]  fill_count;
  } out_word_t;

endpackage

// File: design/ols_ram.sv
// list entry memory, one write and one registered read port
`timescale 1ns / 1ps

module ols_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_array [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_array[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_array[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/ols_ctrl.sv
// request sequencer: decodes an action, walks the memory, builds the result word
`timescale 1ns / 1ps

module ols_ctrl #(
  parameter int CAPACITY = 16,
  parameter int LW       = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  ols_pkg::in_word_t           in_word,
  output logic                        in_stall,
  output logic                        res_valid,
  output ols_pkg::out_word_t          res_word,
  input  logic                        res_take,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_wa,
  output logic [LW-1:0]               mem_wd,
  output logic                        mem_re,
  output logic [$clog2(CAPACITY)-1:0] mem_ra,
  input  logic [LW-1:0]               mem_rd
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    act_r, act_nxt;
  logic [LW-1:0] w_r, w_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [LW-1:0] rword_r, rword_nxt;
  logic [AW-1:0] fpos_r, fpos_nxt;
  logic          pos_ok;

  // start or index lies inside the filled part
  assign pos_ok = 32'(in_word.position) < 32'(cnt_r);

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    w_nxt      = w_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    rword_nxt  = rword_r;
    fpos_nxt   = fpos_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = w_r;
    mem_re     = 1'b0;
    mem_ra     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_word.action;
          w_nxt      = LW'(in_word.word_value);
          status_nxt = ols_pkg::ST_OK;
          rword_nxt  = '0;
          fpos_nxt   = '0;
          state_nxt  = S_RES;
          case (in_word.action)
            ols_pkg::ACT_APPEND: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                status_nxt = ols_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = AW'(cnt_r);
                mem_wd  = LW'(in_word.word_value);
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            ols_pkg::ACT_READ: begin
              if (pos_ok) begin
                mem_re    = 1'b1;
                mem_ra    = AW'(in_word.position);
                state_nxt = S_READ;
              end else begin
                status_nxt = ols_pkg::ST_RANGE;
              end
            end
            ols_pkg::ACT_FIND, ols_pkg::ACT_REMOVE: begin
              if (pos_ok) begin
                mem_re    = 1'b1;
                mem_ra    = AW'(in_word.position);
                idx_nxt   = AW'(in_word.position);
                state_nxt = S_SCAN;
              end else begin
                status_nxt = ols_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        rword_nxt = mem_rd;
        state_nxt = S_RES;
      end
      S_SCAN: begin
        // next entry is fetched ahead; it also feeds the first shift step
        mem_re = 1'b1;
        mem_ra = AW'(CW'(idx_r) + CW'(1));
        if (mem_rd == w_r) begin
          if (act_r == ols_pkg::ACT_FIND) begin
            fpos_nxt  = idx_r;
            state_nxt = S_RES;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (CW'(idx_r) + CW'(1) >= cnt_r) begin
          status_nxt = ols_pkg::ST_NOT_FOUND;
          state_nxt  = S_RES;
        end else begin
          idx_nxt = AW'(CW'(idx_r) + CW'(1));
        end
      end
      S_SHIFT: begin
        // mem_rd holds entry idx+1, moved down to idx
        if (CW'(idx_r) + CW'(1) < cnt_r) begin
          mem_we  = 1'b1;
          mem_wa  = idx_r;
          mem_wd  = mem_rd;
          mem_re  = 1'b1;
          mem_ra  = AW'(CW'(idx_r) + CW'(2));
          idx_nxt = AW'(CW'(idx_r) + CW'(1));
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    w_r      <= w_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    rword_r  <= rword_nxt;
    fpos_r   <= fpos_nxt;
  end

  assign in_stall                = (state_r != S_IDLE);
  assign res_valid               = (state_r == S_RES);
  assign res_word.status         = status_r;
  assign res_word.read_word      = 32'(rword_r);
  assign res_word.found_position = 4'(fpos_r);
  assign res_word.fill_count     = 5'(cnt_r);

endmodule

// File: design/ordered_list_search_remove_top.sv
// top level of the ordered list search and remove block
`timescale 1ns / 1ps

// channel | direction | handshake          | word
// in_     | input     | in_valid/in_stall   | ols_pkg::in_word_t (action, word, position)
// out_    | output    | out_valid/out_stall | ols_pkg::out_word_t (status, data, pos, count)
//
// append, count and undefined actions: accept goes straight to the result state, then the output register
// read: one registered memory read in S_READ, then the result state
// find: k entries compared in S_SCAN from the start position, one per cycle
// remove: find walk, then S_SHIFT moves one entry down per cycle on the memory port
// sync active-low reset clears the fill count and control; entries are not cleared
// out_stall holds the output register; the next word is accepted while it waits, but its result then waits in S_RES

module ordered_list_search_remove_top #(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ols_pkg::in_word_t  in_word,
  output logic               in_stall,
  output logic               out_valid,
  output ols_pkg::out_word_t out_word,
  input  logic               out_stall
);

  // stored word width: the input word carries at most 32 bits
  localparam int LW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam int AW = $clog2(CAPACITY);

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [LW-1:0]      mem_wd;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  logic [LW-1:0]      mem_rd;
  logic               res_valid;
  ols_pkg::out_word_t res_word;
  logic               res_take;

  logic               out_valid_r, out_valid_nxt;
  ols_pkg::out_word_t out_word_r;

  // entry storage
  ols_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (LW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // sequencer over the memory
  ols_ctrl #(
    .CAPACITY (CAPACITY),
    .LW       (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_word  (res_word),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .mem_re    (mem_re),
    .mem_ra    (mem_ra),
    .mem_rd    (mem_rd)
  );

  // output register loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
